[rtl/vbbt_pkg.sv]
// Shared types and constants for the voxel bounding box tracker.
package vbbt_pkg;

    localparam int AXIS_BITS_DEF = 5;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE          = 2'd0,
        ST_ADD_OCCUPIED  = 2'd1,
        ST_REMOVE_ABSENT = 2'd2
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic capture;
        logic eval;
        logic scan;
    } vbbt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic rescan;
        logic scan_last;
    } vbbt_stat_t;

endpackage

[rtl/vbbt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module vbbt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/vbbt_ctrl.sv]
// Sequencer: clearing pass, lookup, evaluate and slice-count rescan.
module vbbt_ctrl import vbbt_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  vbbt_stat_t stat,
    output vbbt_cmd_t  cmd,
    output logic       busy,
    output logic       done
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_EVAL,
        S_SCAN
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (stat.rescan)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign cmd.clear   = (state_reg == S_CLEAR);
    assign cmd.capture = (state_reg == S_IDLE) && start;
    assign cmd.eval    = (state_reg == S_EVAL);
    assign cmd.scan    = (state_reg == S_SCAN);
    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;

endmodule

[rtl/vbbt_dp.sv]
// Datapath: occupancy map, slice counts, box registers and scan logic.
module vbbt_dp import vbbt_pkg::*; #(
    parameter int AXIS_BITS = AXIS_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  vbbt_cmd_t                   cmd,
    output vbbt_stat_t                  stat,
    input  logic                        operation,
    input  logic signed [AXIS_BITS-1:0] cell_x,
    input  logic signed [AXIS_BITS-1:0] cell_y,
    input  logic signed [AXIS_BITS-1:0] cell_z,
    output logic [1:0]                  status,
    output logic                        box_changed,
    output logic                        grid_empty,
    output logic signed [AXIS_BITS-1:0] box_min_x,
    output logic signed [AXIS_BITS-1:0] box_min_y,
    output logic signed [AXIS_BITS-1:0] box_min_z,
    output logic signed [AXIS_BITS-1:0] box_max_x,
    output logic signed [AXIS_BITS-1:0] box_max_y,
    output logic signed [AXIS_BITS-1:0] box_max_z
);

    localparam int CELL_BITS = 3 * AXIS_BITS;
    localparam int CELLS     = 1 << CELL_BITS;
    localparam int SIDE      = 1 << AXIS_BITS;
    localparam int CNT_BITS  = 2 * AXIS_BITS + 1;
    localparam int TOT_BITS  = 3 * AXIS_BITS + 1;

    logic                        op_reg;
    logic signed [AXIS_BITS-1:0] coord_reg  [3];
    logic signed [AXIS_BITS-1:0] old_lo_reg [3];
    logic signed [AXIS_BITS-1:0] old_hi_reg [3];
    logic signed [AXIS_BITS-1:0] lo_reg     [3];
    logic signed [AXIS_BITS-1:0] hi_reg     [3];
    logic [2:0]                  found_reg;
    logic [TOT_BITS-1:0]         total_reg;
    status_t                     status_reg;
    logic                        first_reg;
    logic [AXIS_BITS:0]          scan_reg;
    logic [CELL_BITS-1:0]        clr_reg;

    logic [CELL_BITS-1:0]        cell_addr;
    logic                        map_bit;
    logic                        map_we;
    logic                        is_add;
    logic                        do_update;
    logic                        on_face;
    logic                        moved;
    logic [AXIS_BITS-1:0]        scan_addr;
    logic [AXIS_BITS:0]          scan_prev;
    logic signed [AXIS_BITS-1:0] scan_coord;
    logic [CNT_BITS-1:0]         cnt_rd    [3];
    logic [CNT_BITS-1:0]         cnt_wdata [3];
    logic [AXIS_BITS-1:0]        cnt_raddr [3];
    logic [AXIS_BITS-1:0]        cnt_waddr [3];

    assign cell_addr = {coord_reg[0], coord_reg[1], coord_reg[2]};
    assign is_add    = (op_reg == OP_ADD);
    assign do_update = is_add ? !map_bit : map_bit;
    assign map_we    = cmd.clear || (cmd.eval && do_update);

    vbbt_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (cmd.clear ? clr_reg : cell_addr),
        .wdata (!cmd.clear && is_add),
        .raddr (cell_addr),
        .rdata (map_bit)
    );

    // scan walks coordinates in signed order: adding HALF flips the top bit
    assign scan_addr  = {~scan_reg[AXIS_BITS-1], scan_reg[AXIS_BITS-2:0]};
    assign scan_prev  = scan_reg - (AXIS_BITS+1)'(1);
    assign scan_coord = $signed({~scan_prev[AXIS_BITS-1], scan_prev[AXIS_BITS-2:0]});

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        assign cnt_raddr[a] = cmd.scan ? scan_addr : $unsigned(coord_reg[a]);
        assign cnt_waddr[a] = cmd.clear ? clr_reg[AXIS_BITS-1:0] : $unsigned(coord_reg[a]);
        assign cnt_wdata[a] = cmd.clear ? '0 :
                              is_add    ? cnt_rd[a] + CNT_BITS'(1) :
                                          cnt_rd[a] - CNT_BITS'(1);

        vbbt_ram #(
            .WIDTH (CNT_BITS),
            .DEPTH (SIDE)
        ) u_cnt (
            .clk   (clk),
            .we    (map_we),
            .waddr (cnt_waddr[a]),
            .wdata (cnt_wdata[a]),
            .raddr (cnt_raddr[a]),
            .rdata (cnt_rd[a])
        );
    end

    always_comb
    begin
        on_face = 1'b0;
        moved   = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            if (coord_reg[a] == lo_reg[a] || coord_reg[a] == hi_reg[a])
            begin
                on_face = 1'b1;
            end
            if (lo_reg[a] != old_lo_reg[a] || hi_reg[a] != old_hi_reg[a])
            begin
                moved = 1'b1;
            end
        end
    end

    assign stat.clear_last = &clr_reg;
    assign stat.rescan     = !is_add && map_bit && on_face && (total_reg != TOT_BITS'(1));
    assign stat.scan_last  = (scan_reg == (AXIS_BITS+1)'(SIDE));

    // item beat capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= operation;
            coord_reg[0] <= cell_x;
            coord_reg[1] <= cell_y;
            coord_reg[2] <= cell_z;
            for (int a = 0; a < 3; a++)
            begin
                old_lo_reg[a] <= lo_reg[a];
                old_hi_reg[a] <= hi_reg[a];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= '0;
            clr_reg    <= '0;
            scan_reg   <= '0;
            found_reg  <= '0;
            status_reg <= ST_DONE;
            first_reg  <= 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                lo_reg[a] <= '0;
                hi_reg[a] <= '0;
            end
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + CELL_BITS'(1);
            end

            if (cmd.eval)
            begin
                scan_reg  <= '0;
                found_reg <= '0;
                first_reg <= 1'b0;
                if (is_add)
                begin
                    if (map_bit)
                    begin
                        status_reg <= ST_ADD_OCCUPIED;
                    end
                    else
                    begin
                        status_reg <= ST_DONE;
                        total_reg  <= total_reg + TOT_BITS'(1);
                        if (total_reg == '0)
                        begin
                            first_reg <= 1'b1;
                            for (int a = 0; a < 3; a++)
                            begin
                                lo_reg[a] <= coord_reg[a];
                                hi_reg[a] <= coord_reg[a];
                            end
                        end
                        else
                        begin
                            for (int a = 0; a < 3; a++)
                            begin
                                if (coord_reg[a] < lo_reg[a])
                                begin
                                    lo_reg[a] <= coord_reg[a];
                                end
                                if (coord_reg[a] > hi_reg[a])
                                begin
                                    hi_reg[a] <= coord_reg[a];
                                end
                            end
                        end
                    end
                end
                else if (!map_bit)
                begin
                    status_reg <= ST_REMOVE_ABSENT;
                end
                else
                begin
                    status_reg <= ST_DONE;
                    total_reg  <= total_reg - TOT_BITS'(1);
                end
            end

            // read data is registered and belongs to the previous scan address
            if (cmd.scan)
            begin
                scan_reg <= scan_reg + (AXIS_BITS+1)'(1);
                if (scan_reg != '0)
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        if (cnt_rd[a] != '0)
                        begin
                            if (!found_reg[a])
                            begin
                                lo_reg[a] <= scan_coord;
                            end
                            hi_reg[a]    <= scan_coord;
                            found_reg[a] <= 1'b1;
                        end
                    end
                end
            end
        end
    end

    assign status      = status_reg;
    assign box_changed = first_reg || moved;
    assign grid_empty  = (total_reg == '0);
    assign box_min_x   = lo_reg[0];
    assign box_min_y   = lo_reg[1];
    assign box_min_z   = lo_reg[2];
    assign box_max_x   = hi_reg[0];
    assign box_max_y   = hi_reg[1];
    assign box_max_z   = hi_reg[2];

endmodule

[rtl/voxel_bounding_box_tracker.sv]
// Top level of the voxel bounding box tracker.
//
//  channel  | handshake          | beat
//  ---------+--------------------+----------------------------------------------
//  item     | start, busy        | operation, cell_x, cell_y, cell_z
//  result   | done (strobe)      | status, box_changed, grid_empty, box_min_*/max_*
//
// An item runs from accept through lookup and evaluate back to idle, where the
// next item can be accepted; removing an occupied cell on a box face, unless it
// is the last one, rescans the three slice-count memories in parallel, one entry
// a cycle. After reset a clearing pass over the occupancy map runs with busy high.
// The result beat shows for one cycle with done; the receiver cannot stall.
module voxel_bounding_box_tracker import vbbt_pkg::*; #(
    parameter int AXIS_BITS = AXIS_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        operation,
    input  logic signed [AXIS_BITS-1:0] cell_x,
    input  logic signed [AXIS_BITS-1:0] cell_y,
    input  logic signed [AXIS_BITS-1:0] cell_z,
    output logic                        done,
    output logic [1:0]                  status,
    output logic                        box_changed,
    output logic                        grid_empty,
    output logic signed [AXIS_BITS-1:0] box_min_x,
    output logic signed [AXIS_BITS-1:0] box_min_y,
    output logic signed [AXIS_BITS-1:0] box_min_z,
    output logic signed [AXIS_BITS-1:0] box_max_x,
    output logic signed [AXIS_BITS-1:0] box_max_y,
    output logic signed [AXIS_BITS-1:0] box_max_z
);

    vbbt_cmd_t  cmd;
    vbbt_stat_t stat;

    vbbt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    vbbt_dp #(
        .AXIS_BITS (AXIS_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .operation   (operation),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .cell_z      (cell_z),
        .status      (status),
        .box_changed (box_changed),
        .grid_empty  (grid_empty),
        .box_min_x   (box_min_x),
        .box_min_y   (box_min_y),
        .box_min_z   (box_min_z),
        .box_max_x   (box_max_x),
        .box_max_y   (box_max_y),
        .box_max_z   (box_max_z)
    );

`ifndef SYNTH
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_ignored_static: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_DONE) |-> !box_changed)
        else $error("ignored item changed the box");

    a_empty_static: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_REMOVE_ABSENT && $past(grid_empty, 3)) |-> grid_empty)
        else $error("ignored remove altered occupancy");
`endif

endmodule
